// ===== rtl/bmhq_pkg.sv =====
// bmhq_pkg: request/result structs and sequencer states for bounded_max_heap_queue
// no dependencies

package bmhq_pkg;

  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_PPUSH = 2'd1,
    ACT_POP   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]                  action;
    logic signed [KEY_WIDTH-1:0] key_in;
    logic [VALUE_WIDTH-1:0]      value_in;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic [31:0]        out_value;
    logic               popped;
    logic               empty_error;
    logic               stored;
    logic               evicted;
    logic [7:0]         entry_count;
  } out_res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EV_RD,
    ST_EV_WR,
    ST_INS_WR,
    ST_UP_RD,
    ST_UP_RDP,
    ST_UP_CMP,
    ST_POP_RD0,
    ST_POP_RDL,
    ST_POP_WR,
    ST_DN_RDI,
    ST_DN_RDJ,
    ST_DN_RDK,
    ST_DN_CMP,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/bounded_max_heap_queue.sv =====
// bounded_max_heap_queue: bounded binary max-heap with leaf-scan eviction
// depends on bmhq_pkg; heap held in one single-port memory with registered read
//
//  channel | ports                      | direction | handshake
//  in      | start, busy, in_req        | in        | start && !busy
//  out     | out_valid, out_res         | out       | one-cycle strobe, no stall
//
// one request at a time; busy is high from acceptance until the result strobe.
// a full-heap push scans the leaves for the minimum key, reading and comparing each leaf,
// then moves the last entry over that leaf, sifts it up, inserts the new entry and sifts up.
// a pop moves the last entry to the root and sifts it down; every request ends in ST_DONE.
// reset clears the entry count; memory contents are never read before written.
// the receiver cannot stall: the result strobe lasts exactly one cycle.

module bounded_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY    = 255
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY + 1) : 1;
  localparam int EW = KEY_WIDTH + VALUE_WIDTH;
  localparam logic [AW-1:0] CAP = AW'(CAPACITY);

  typedef logic [AW-1:0] addr_t;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic          we;
  addr_t         mem_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[mem_addr] <= wr_data;
    end
    rd_data <= mem[mem_addr];
  end

  state_t state_r, state_nxt;
  addr_t count_r, count_nxt;
  logic [1:0] act_r, act_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  // a, b: working entries; i, j, k: slot indexes
  logic [EW-1:0] ea_r, ea_nxt, eb_r, eb_nxt;
  addr_t i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, best_r, best_nxt;
  logic [KEY_WIDTH-1:0] bkey_r, bkey_nxt;
  out_res_t res_r, res_nxt;
  logic out_valid_r;

  function automatic logic key_lt(input logic [KEY_WIDTH-1:0] a, input logic [KEY_WIDTH-1:0] b);
    key_lt = $signed(a) < $signed(b);
  endfunction

  function automatic logic [KEY_WIDTH-1:0] kof(input logic [EW-1:0] e);
    kof = e[EW-1:VALUE_WIDTH];
  endfunction

  addr_t last, scan_start, parent;
  logic [AW:0] lc, rc;
  always_comb begin
    last = count_r - addr_t'(1);
    scan_start = count_r[0] ? addr_t'(last >> 1) : addr_t'((last >> 1) + addr_t'(1));
    parent = addr_t'((i_r - addr_t'(1)) >> 1);
    lc = {i_r, 1'b1};
    rc = {i_r, 1'b1} + (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_nxt == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    best_r <= best_nxt;
    bkey_r <= bkey_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    act_nxt = act_r;
    key_nxt = key_r;
    val_nxt = val_r;
    ea_nxt = ea_r;
    eb_nxt = eb_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    best_nxt = best_r;
    bkey_nxt = bkey_r;
    res_nxt = res_r;
    we = 1'b0;
    mem_addr = i_r;
    wr_data = ea_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt = in_req.action;
          key_nxt = KEY_WIDTH'(in_req.key_in);
          val_nxt = VALUE_WIDTH'(in_req.value_in);
          res_nxt = '0;
          ea_nxt = {KEY_WIDTH'(in_req.key_in), VALUE_WIDTH'(in_req.value_in)};
          case (in_req.action)
            ACT_PUSH: begin
              if (count_r >= CAP) begin
                i_nxt = scan_start;
                best_nxt = scan_start;
                state_nxt = ST_SCAN_RD;
              end else begin
                state_nxt = ST_INS_WR;
              end
            end
            ACT_PPUSH: begin
              if (count_r == '0) begin
                state_nxt = ST_INS_WR;
              end else begin
                i_nxt = scan_start;
                best_nxt = scan_start;
                state_nxt = ST_SCAN_RD;
              end
            end
            ACT_POP: begin
              if (count_r == '0) begin
                res_nxt.empty_error = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                i_nxt = '0;
                state_nxt = ST_POP_RD0;
              end
            end
            default: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        mem_addr = i_r;
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (i_r == best_r || key_lt(kof(rd_data), bkey_r)) begin
          best_nxt = i_r;
          bkey_nxt = kof(rd_data);
        end
        if (i_r + addr_t'(1) < count_r) begin
          i_nxt = i_r + addr_t'(1);
          state_nxt = ST_SCAN_RD;
        end else begin
          // decide with the minimum in hand
          if (i_r == best_r || key_lt(kof(rd_data), bkey_r)) begin
            bkey_nxt = kof(rd_data);
          end
          state_nxt = ST_DONE;
          if (act_r == ACT_PUSH) begin
            if (key_lt(i_r == best_r || key_lt(kof(rd_data), bkey_r) ? kof(rd_data) : bkey_r,
                       key_r)) begin
              state_nxt = ST_EV_RD;
            end
          end else begin
            if (!key_lt(key_r,
                        i_r == best_r || key_lt(kof(rd_data), bkey_r) ? kof(rd_data) : bkey_r)) begin
              state_nxt = (count_r >= CAP) ? ST_EV_RD : ST_INS_WR;
            end
          end
        end
      end
      ST_EV_RD: begin
        mem_addr = last;
        state_nxt = ST_EV_WR;
      end
      ST_EV_WR: begin
        mem_addr = best_r;
        wr_data = rd_data;
        we = 1'b1;
        res_nxt.evicted = 1'b1;
        count_nxt = last;
        eb_nxt = rd_data;
        i_nxt = best_r;
        if (last > addr_t'(1) && best_r != last) begin
          state_nxt = ST_UP_RDP;
        end else begin
          state_nxt = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        ea_nxt = {key_r, val_r};
        eb_nxt = {key_r, val_r};
        mem_addr = count_r;
        wr_data = {key_r, val_r};
        we = 1'b1;
        res_nxt.stored = 1'b1;
        count_nxt = count_r + addr_t'(1);
        i_nxt = count_r;
        act_nxt = ACT_CLEAR;
        state_nxt = (count_r != '0) ? ST_UP_RDP : ST_DONE;
      end
      ST_UP_RDP: begin
        // eb holds entry at slot i
        mem_addr = parent;
        state_nxt = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (key_lt(kof(eb_r), kof(rd_data))) begin
          state_nxt = (act_r == ACT_CLEAR) ? ST_DONE : ST_INS_WR;
        end else begin
          mem_addr = i_r;
          wr_data = rd_data;
          we = 1'b1;
          state_nxt = ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        mem_addr = parent;
        wr_data = eb_r;
        we = 1'b1;
        i_nxt = parent;
        if (parent == '0) begin
          state_nxt = (act_r == ACT_CLEAR) ? ST_DONE : ST_INS_WR;
        end else begin
          state_nxt = ST_UP_RDP;
        end
      end
      ST_POP_RD0: begin
        mem_addr = '0;
        state_nxt = ST_POP_RDL;
      end
      ST_POP_RDL: begin
        res_nxt.out_key = 32'(kof(rd_data));
        res_nxt.out_value = 32'(rd_data[VALUE_WIDTH-1:0]);
        res_nxt.popped = 1'b1;
        mem_addr = last;
        state_nxt = ST_POP_WR;
      end
      ST_POP_WR: begin
        mem_addr = '0;
        wr_data = rd_data;
        we = 1'b1;
        ea_nxt = rd_data;
        count_nxt = last;
        i_nxt = '0;
        state_nxt = (last > addr_t'(1)) ? ST_DN_RDJ : ST_DONE;
      end
      ST_DN_RDJ: begin
        // ea holds entry at slot i
        if (lc >= {1'b0, count_r}) begin
          state_nxt = ST_DONE;
        end else begin
          mem_addr = addr_t'(lc);
          j_nxt = addr_t'(lc);
          state_nxt = ST_DN_RDK;
        end
      end
      ST_DN_RDK: begin
        eb_nxt = rd_data;
        if (rc < {1'b0, count_r}) begin
          mem_addr = addr_t'(rc);
          k_nxt = addr_t'(rc);
          state_nxt = ST_DN_RDI;
        end else begin
          state_nxt = ST_DN_CMP;
        end
      end
      ST_DN_RDI: begin
        if (key_lt(kof(eb_r), kof(rd_data))) begin
          eb_nxt = rd_data;
          j_nxt = k_r;
        end
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (!key_lt(kof(ea_r), kof(eb_r))) begin
          state_nxt = ST_DONE;
        end else begin
          mem_addr = i_r;
          wr_data = eb_r;
          we = 1'b1;
          i_nxt = j_r;
          state_nxt = ST_DN_RDJ;
        end
      end
      ST_DONE: begin
        res_nxt.entry_count = 8'(count_r);
        state_nxt = ST_IDLE;
        if (act_r == ACT_POP && res_r.popped && i_r != '0) begin
          mem_addr = i_r;
          wr_data = ea_r;
          we = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  always_comb begin
    out_res = res_r;
    out_res.entry_count = 8'(count_r);
  end

endmodule

// ===== sim/tb_bounded_max_heap_queue.sv =====
// tb_bounded_max_heap_queue: self-checking bench for the bounded max-heap queue
// drives requests through start/busy and checks every result strobe against a heap predictor
// depends on bmhq_pkg and bounded_max_heap_queue
`timescale 1ns / 100ps

module tb_bounded_max_heap_queue;
  import bmhq_pkg::*;

  localparam int CAP = 255;
  localparam int RANDOM_REQS = 950;
  localparam longint CYCLE_LIMIT = 2000000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_req = '0;
  logic     out_valid;
  out_res_t out_res;

  logic signed [31:0] model_keys [CAP];
  logic [31:0]        model_vals [CAP];
  int                 model_count;
  out_res_t           pending_results [$];
  int                 errors = 0;
  longint             cycles = 0;

  typedef struct {
    in_req_t  req;
    logic     known;
    out_res_t res;
  } dir_row_t;
  dir_row_t dir_rows [$];

  bounded_max_heap_queue uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always #4 clk = ~clk;

  function automatic void swap_slots(int a, int b);
    logic signed [31:0] tk;
    logic [31:0] tv;
    tk = model_keys[a]; model_keys[a] = model_keys[b]; model_keys[b] = tk;
    tv = model_vals[a]; model_vals[a] = model_vals[b]; model_vals[b] = tv;
  endfunction

  function automatic void sift_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (model_keys[p] > model_keys[i]) break;
      swap_slots(p, i);
      i = p;
    end
  endfunction

  function automatic void sift_down();
    int i, j, k;
    i = 0;
    forever begin
      j = 2 * i + 1;
      k = j + 1;
      if (j >= model_count) break;
      if (k < model_count && model_keys[j] < model_keys[k]) j = k;
      if (model_keys[i] >= model_keys[j]) break;
      swap_slots(i, j);
      i = j;
    end
  endfunction

  function automatic int min_leaf();
    int first, best;
    first = (model_count % 2) ? (model_count - 1) / 2 : (model_count - 1) / 2 + 1;
    best = first;
    for (int i = first + 1; i < model_count; i++)
      if (model_keys[i] < model_keys[best]) best = i;
    return best;
  endfunction

  function automatic void evict_min(int m);
    int last;
    last = model_count - 1;
    model_keys[m] = model_keys[last];
    model_vals[m] = model_vals[last];
    model_count--;
    if (model_count > 1 && m != last) sift_up(m);
  endfunction

  function automatic void heap_insert(logic signed [31:0] k, logic [31:0] v);
    model_keys[model_count] = k;
    model_vals[model_count] = v;
    model_count++;
    if (model_count > 1) sift_up(model_count - 1);
  endfunction

  function automatic out_res_t predict_heap_op(in_req_t r);
    out_res_t o;
    int m;
    o = '0;
    case (action_t'(r.action))
      ACT_PUSH: begin
        if (model_count >= CAP) begin
          m = min_leaf();
          if (r.key_in > model_keys[m]) begin
            evict_min(m);
            o.evicted = 1'b1;
            heap_insert(r.key_in, r.value_in);
            o.stored = 1'b1;
          end
        end else begin
          heap_insert(r.key_in, r.value_in);
          o.stored = 1'b1;
        end
      end
      ACT_PPUSH: begin
        if (model_count == 0) begin
          heap_insert(r.key_in, r.value_in);
          o.stored = 1'b1;
        end else begin
          m = min_leaf();
          if (r.key_in >= model_keys[m]) begin
            if (model_count >= CAP) begin
              evict_min(m);
              o.evicted = 1'b1;
            end
            heap_insert(r.key_in, r.value_in);
            o.stored = 1'b1;
          end
        end
      end
      ACT_POP: begin
        if (model_count != 0) begin
          o.out_key = model_keys[0];
          o.out_value = model_vals[0];
          o.popped = 1'b1;
          model_keys[0] = model_keys[model_count - 1];
          model_vals[0] = model_vals[model_count - 1];
          model_count--;
          if (model_count > 1) sift_down();
        end else begin
          o.empty_error = 1'b1;
        end
      end
      default: model_count = 0;
    endcase
    o.entry_count = model_count[7:0];
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bounded_max_heap_queue test failed");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
      end else begin
        out_res_t e;
        e = pending_results.pop_front();
        if (out_res.out_key !== e.out_key) begin
          $error("out_key exp %0d got %0d", e.out_key, out_res.out_key); errors++;
        end
        if (out_res.out_value !== e.out_value) begin
          $error("out_value exp %0h got %0h", e.out_value, out_res.out_value); errors++;
        end
        if (out_res.popped !== e.popped) begin
          $error("popped exp %0b got %0b", e.popped, out_res.popped); errors++;
        end
        if (out_res.empty_error !== e.empty_error) begin
          $error("empty_error exp %0b got %0b", e.empty_error, out_res.empty_error); errors++;
        end
        if (out_res.stored !== e.stored) begin
          $error("stored exp %0b got %0b", e.stored, out_res.stored); errors++;
        end
        if (out_res.evicted !== e.evicted) begin
          $error("evicted exp %0b got %0b", e.evicted, out_res.evicted); errors++;
        end
        if (out_res.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_res.entry_count); errors++;
        end
      end
    end
  end

  task automatic send_request(in_req_t r, logic known, out_res_t exp_res, int gap);
    out_res_t p;
    repeat (gap + 1) @(negedge clk);
    in_req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_heap_op(r);
    if (known && p !== exp_res) begin
      $error("directed row mismatch for action %0d", r.action);
      errors++;
    end
    pending_results.push_back(p);
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic in_req_t mk_req(action_t a, logic [31:0] k, logic [31:0] v);
    in_req_t r;
    r.action = a;
    r.key_in = k;
    r.value_in = v;
    return r;
  endfunction

  function automatic out_res_t mk_res(logic [31:0] k, logic [31:0] v, logic pp, logic ee,
                                      logic st, logic ev, logic [7:0] n);
    out_res_t o;
    o.out_key = k; o.out_value = v; o.popped = pp; o.empty_error = ee;
    o.stored = st; o.evicted = ev; o.entry_count = n;
    return o;
  endfunction

  task automatic add_row(in_req_t r, logic known, out_res_t o);
    dir_row_t d;
    d.req = r; d.known = known; d.res = o;
    dir_rows.push_back(d);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h8000_0000;
    if (sel == 1) return 32'h7fff_ffff;
    if (sel < 5) return $urandom_range(0, 15) - 8;
    return $urandom;
  endfunction

  initial begin
    in_req_t r;
    int gap, act_sel, mode;
    model_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(mk_req(ACT_POP, 32'h1234, 32'h5678), 1, mk_res(0, 0, 0, 1, 0, 0, 0));
    add_row(mk_req(ACT_PUSH, 32'h7fff_ffff, 32'hffff_ffff), 1, mk_res(0, 0, 0, 0, 1, 0, 1));
    add_row(mk_req(ACT_POP, 0, 0), 1, mk_res(32'h7fff_ffff, 32'hffff_ffff, 1, 0, 0, 0, 0));
    add_row(mk_req(ACT_PPUSH, 32'h8000_0000, 32'h0), 1, mk_res(0, 0, 0, 0, 1, 0, 1));
    add_row(mk_req(ACT_PPUSH, 32'h8000_0000, 32'h1), 0, '0);
    add_row(mk_req(ACT_PUSH, 5, 32'haaaa_5555), 0, '0);
    add_row(mk_req(ACT_PUSH, 5, 32'h5555_aaaa), 0, '0);
    add_row(mk_req(ACT_PPUSH, 32'hffff_ffff, 7), 0, '0);
    add_row(mk_req(ACT_POP, 0, 0), 0, '0);
    add_row(mk_req(ACT_POP, 0, 0), 0, '0);
    add_row(mk_req(ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff), 1, mk_res(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ACT_POP, 0, 0), 1, mk_res(0, 0, 0, 1, 0, 0, 0));
    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res, $urandom_range(0, 2));

    // fill to capacity, then exercise eviction and drops when full
    for (int i = 0; i < CAP + 40; i++) begin
      r = mk_req(($urandom_range(0, 1)) ? ACT_PUSH : ACT_PPUSH, rand_key(), $urandom);
      send_request(r, 0, '0, (i % 7 == 0) ? $urandom_range(0, 18) : 0);
    end
    wait_drain();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      mode = (i / 150) % 4;
      act_sel = $urandom_range(0, 99);
      if (mode == 0)
        r.action = (act_sel < 45) ? ACT_PUSH : (act_sel < 80) ? ACT_PPUSH :
                   (act_sel < 99) ? ACT_POP : ACT_CLEAR;
      else if (mode == 1)
        r.action = (act_sel < 25) ? ACT_PUSH : (act_sel < 40) ? ACT_PPUSH :
                   (act_sel < 98) ? ACT_POP : ACT_CLEAR;
      else
        r.action = (act_sel < 40) ? ACT_PUSH : (act_sel < 70) ? ACT_PPUSH :
                   (act_sel < 97) ? ACT_POP : ACT_CLEAR;
      r.key_in = rand_key();
      r.value_in = $urandom;
      gap = ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, 18);
      send_request(r, 0, '0, gap);
      if (i == RANDOM_REQS / 2) wait_drain();
    end

    wait_drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("bounded_max_heap_queue test passed");
    end else begin
      $display("bounded_max_heap_queue test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bmhq_pkg.sv
rtl/bounded_max_heap_queue.sv
sim/tb_bounded_max_heap_queue.sv
